// ===== rtl/core/tgg_pkg.sv =====
// tgg_pkg: constants, trig table and saturation helper for the tripod gait generator
// no dependencies; used by tgg_div and tripod_gait_generator
package tgg_pkg;

	localparam int LEG_COUNT = 6;
	localparam int LEG_W     = $clog2(LEG_COUNT);
	localparam int TRIG_N    = 256;
	localparam int TRIG_W    = $clog2(TRIG_N);
	localparam int TRIG_VW   = 18;
	localparam int QTR_TURN  = TRIG_N / 4;
	localparam int PHASE_W   = 8;
	localparam int CMD_W     = 16;
	localparam int POS_W     = 32;
	localparam int Z_W       = 16;
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 16;

	localparam int NUM_W = PHASE_W + TRIG_W + 1;
	localparam int DEN_W = PHASE_W + 1;

	localparam int INV_PI_Q24 = 5340354;
	localparam int LK_W       = PHASE_W + 23;
	localparam int OPD_W      = 34;
	localparam int PROD_W     = 2 * OPD_W;
	localparam int ACC_W      = 50;
	localparam int P0_W       = 34;
	localparam int THRESH_LIN = 65;
	localparam int THRESH_YAW = 285;

	localparam logic [CFG_AW-1:0] REG_VSCALE = 3'd0;
	localparam logic [CFG_AW-1:0] REG_CLEN   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ALPHA  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_LIFT   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_FINISH = 3'd4;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	typedef logic signed [TRIG_VW-1:0] trig_tab_t [TRIG_N];

	// shift and subtract quotient, only evaluated while building the table
	function automatic longint unsigned udiv_u64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned qv, rv;
		qv = '0;
		rv = '0;
		for (int b = 63; b >= 0; b--) begin
			rv = {rv[62:0], n[b]};
			if (rv >= d) begin
				rv    = rv - d;
				qv[b] = 1'b1;
			end
		end
		return qv;
	endfunction

	function automatic logic signed [TRIG_VW-1:0] trig_entry(input int k);
		longint unsigned m4, q, r, x, x2, term, val;
		longint sum;
		m4 = longint'(4 * k);
		q = (m4 >> TRIG_W) & 64'd3;
		r = m4 & longint'(TRIG_N - 1);
		if (q[0])
			r = longint'(TRIG_N) - r;
		x = (HALF_PI_Q30 * r) >> TRIG_W;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int i = 1; i <= 7; i++) begin
			term = udiv_u64((term * x2) >> 30, TAYLOR_DIV[i-1]);
			if (i[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > ONE_Q30)
			sum = ONE_Q30;
		val = (longint'(sum) + 64'd8192) >> 14;
		if (q[1])
			return TRIG_VW'(-longint'(val));
		return TRIG_VW'(val);
	endfunction

	function automatic trig_tab_t trig_table();
		trig_tab_t t;
		for (int k = 0; k < TRIG_N; k++)
			t[k] = trig_entry(k);
		return t;
	endfunction

	localparam trig_tab_t TRIG_TAB = trig_table();

	function automatic logic [LEG_COUNT-1:0] grp_reset();
		logic [LEG_COUNT-1:0] g;
		for (int i = 0; i < LEG_COUNT; i++)
			g[i] = i[0];
		return g;
	endfunction

	localparam logic [LEG_COUNT-1:0] GRP_RST = grp_reset();

	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sd2147483647);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		if (v > SAT_HI)
			return SAT_HI[POS_W-1:0];
		if (v < SAT_LO)
			return SAT_LO[POS_W-1:0];
		return v[POS_W-1:0];
	endfunction

endpackage

// ===== rtl/core/tgg_div.sv =====
// tgg_div: restoring divider, one quotient bit per cycle
// depends on tgg_pkg
module tgg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tgg_pkg::NUM_W-1:0]  num,
	input  logic [tgg_pkg::DEN_W-1:0]  den,
	output logic                       done,
	output logic [tgg_pkg::NUM_W-1:0]  quo
);
	import tgg_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(NUM_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/core/tripod_gait_generator.sv =====
// tripod_gait_generator: velocity command filter and tripod foot trajectory sequencer
// depends on tgg_pkg and tgg_div
// each request runs the filters and, while stepping, the trig divide and foot ops,
//   then six leg results one per cycle while out_ready allows; uses one shared 34x34
//   multiplier for 17 (idle: 13) operations and a 17-step bit-serial trig index divider
// a new request is taken only in idle, after all six legs are out and the phase updated
// reset: registers to their defaults, filters and phase cleared, even legs lifted
module tripod_gait_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tgg_pkg::CFG_AW-1:0]          cfg_index,
	input  logic [tgg_pkg::CFG_DW-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tgg_pkg::CMD_W-1:0]    cmd_x,
	input  logic signed [tgg_pkg::CMD_W-1:0]    cmd_y,
	input  logic signed [tgg_pkg::CMD_W-1:0]    cmd_yaw,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tgg_pkg::LEG_W-1:0]           leg,
	output logic signed [tgg_pkg::POS_W-1:0]    pos_x,
	output logic signed [tgg_pkg::POS_W-1:0]    pos_y,
	output logic [tgg_pkg::Z_W-1:0]             pos_z,
	output logic signed [tgg_pkg::POS_W-1:0]    foot_yaw,
	output logic                                moving,
	output logic                                last_leg
);
	import tgg_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_WB   = 8'b0000_0100,
		ST_FLAG = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_LUT  = 8'b0010_0000,
		ST_OUT  = 8'b0100_0000,
		ST_UPD  = 8'b1000_0000
	} state_t;

	typedef enum logic [4:0] {
		OP_LK, OP_VX, OP_SX, OP_AX, OP_FX, OP_VY, OP_SY, OP_AY, OP_FY,
		OP_VW, OP_SW, OP_AW, OP_FW, OP_PX, OP_PY, OP_PW, OP_PZ
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic [CFG_DW-1:0]  vscale_q;
	logic [PHASE_W-1:0] clen_q;
	logic [CFG_DW-1:0]  alpha_q;
	logic [Z_W-1:0]     lift_q;
	logic               finish_q;

	logic signed [CMD_W-1:0] cx_q, cy_q, cw_q;
	logic signed [POS_W-1:0] smx_q, smy_q, smw_q;
	logic [PHASE_W-1:0]      phase_q;
	logic [LEG_COUNT-1:0]    grp_q;
	logic                    trav_q;

	logic [LK_W-1:0]           lk_q;
	logic signed [32:0]        v_q;
	logic signed [POS_W-1:0]   st_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [TRIG_VW-1:0] s_q, c_q;
	logic signed [P0_W-1:0]    px0_q, py0_q, pw0_q;
	logic [Z_W-1:0]            pz_q;
	logic [LEG_W-1:0]          leg_q;

	logic                     out_valid_q;
	logic [LEG_W-1:0]         out_leg_q;
	logic signed [POS_W-1:0]  out_x_q, out_y_q, out_w_q;
	logic [Z_W-1:0]           out_z_q;
	logic                     out_mov_q;
	logic                     out_last_q;

	logic [PHASE_W-1:0]       len_eff;
	logic [16:0]              alpha_c;
	logic signed [OPD_W-1:0]  opa, opb;
	logic                     trav_new;
	logic                     stepping;
	logic                     div_start;
	logic                     div_done;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic [NUM_W-1:0]         div_quo;
	logic [TRIG_W-1:0]        k_sin, k_cos;
	logic signed [PROD_W-1:0] mix_sum;
	logic signed [PROD_W-1:0] pz_full;
	logic [PHASE_W-1:0]       phase_nx;
	logic                     load_out;
	logic                     lifted;

	assign len_eff  = (clen_q == '0) ? PHASE_W'(1) : clen_q;
	assign alpha_c  = 17'h10000 - {1'b0, alpha_q};
	assign stepping = trav_q | finish_q;
	assign in_ready = (state_q == ST_IDLE);

	assign trav_new = (smx_q > POS_W'(THRESH_LIN)) || (smx_q < -POS_W'(THRESH_LIN))
		|| (smy_q > POS_W'(THRESH_LIN)) || (smy_q < -POS_W'(THRESH_LIN))
		|| (smw_q > POS_W'(THRESH_YAW)) || (smw_q < -POS_W'(THRESH_YAW));

	always_comb begin
		opa = '0;
		opb = '0;
		case (op_q)
			OP_LK: begin opa = OPD_W'(len_eff); opb = OPD_W'(INV_PI_Q24); end
			OP_VX: begin opa = OPD_W'(cx_q); opb = OPD_W'(vscale_q); end
			OP_VY: begin opa = OPD_W'(cy_q); opb = OPD_W'(vscale_q); end
			OP_VW: begin opa = OPD_W'(cw_q); opb = OPD_W'(vscale_q); end
			OP_SX, OP_SY, OP_SW: begin opa = OPD_W'(v_q); opb = OPD_W'(lk_q); end
			OP_AX, OP_AY, OP_AW: begin opa = OPD_W'(st_q); opb = OPD_W'(alpha_q); end
			OP_FX: begin opa = OPD_W'(smx_q); opb = OPD_W'(alpha_c); end
			OP_FY: begin opa = OPD_W'(smy_q); opb = OPD_W'(alpha_c); end
			OP_FW: begin opa = OPD_W'(smw_q); opb = OPD_W'(alpha_c); end
			OP_PX: begin opa = OPD_W'(smx_q); opb = OPD_W'(c_q); end
			OP_PY: begin opa = OPD_W'(smy_q); opb = OPD_W'(c_q); end
			OP_PW: begin opa = OPD_W'(smw_q); opb = OPD_W'(c_q); end
			OP_PZ: begin opa = OPD_W'(lift_q); opb = OPD_W'(s_q); end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign mix_sum = (PROD_W'(acc_q) + prod_q) >>> 16;
	assign pz_full = prod_q >>> 16;

	// trig index from phase over cycle length
	assign div_start = (state_q == ST_FLAG) && (trav_new || finish_q);
	assign div_num   = NUM_W'({phase_q, {TRIG_W{1'b0}}}) + NUM_W'(len_eff);
	assign div_den   = {len_eff, 1'b0};
	assign k_sin     = div_quo[TRIG_W-1:0];
	assign k_cos     = k_sin + TRIG_W'(QTR_TURN);

	tgg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign phase_nx = stepping ? phase_q + PHASE_W'(1) : '0;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign lifted   = !grp_q[leg_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_LK;
			vscale_q    <= 16'd256;
			clen_q      <= 8'd50;
			alpha_q     <= 16'd32768;
			lift_q      <= 16'd3277;
			finish_q    <= 1'b0;
			smx_q       <= '0;
			smy_q       <= '0;
			smw_q       <= '0;
			phase_q     <= '0;
			grp_q       <= GRP_RST;
			trav_q      <= 1'b0;
			leg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VSCALE: vscale_q <= cfg_data;
					REG_CLEN:   clen_q   <= cfg_data[PHASE_W-1:0];
					REG_ALPHA:  alpha_q  <= cfg_data;
					REG_LIFT:   lift_q   <= cfg_data;
					REG_FINISH: finish_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= OP_LK;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_WB;
				ST_WB: begin
					case (op_q)
						OP_FX: smx_q <= sat32(mix_sum);
						OP_FY: smy_q <= sat32(mix_sum);
						OP_FW: smw_q <= sat32(mix_sum);
						default: ;
					endcase
					if (op_q == OP_FW) begin
						state_q <= ST_FLAG;
					end else if (op_q == OP_PZ) begin
						leg_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						op_q    <= op_t'(op_q + 5'd1);
						state_q <= ST_MUL;
					end
				end
				ST_FLAG: begin
					trav_q <= trav_new;
					if (trav_new || finish_q) begin
						state_q <= ST_DIV;
					end else begin
						leg_q   <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_LUT;
				end
				ST_LUT: begin
					op_q    <= OP_PX;
					state_q <= ST_MUL;
				end
				ST_OUT: begin
					if (load_out) begin
						if (leg_q == LEG_W'(LEG_COUNT - 1))
							state_q <= ST_UPD;
						else
							leg_q <= leg_q + LEG_W'(1);
					end
				end
				ST_UPD: begin
					if (phase_nx == len_eff) begin
						phase_q <= '0;
						grp_q   <= ~grp_q;
					end else begin
						phase_q <= phase_nx;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cx_q <= cmd_x;
			cy_q <= cmd_y;
			cw_q <= cmd_yaw;
		end
		if (state_q == ST_MUL)
			prod_q <= opa * opb;
		if (state_q == ST_WB) begin
			case (op_q)
				OP_LK: lk_q <= prod_q[LK_W-1:0];
				OP_VX, OP_VY, OP_VW: v_q <= 33'(prod_q >>> 4);
				OP_SX, OP_SY, OP_SW: st_q <= sat32(prod_q >>> 24);
				OP_AX, OP_AY, OP_AW: acc_q <= prod_q[ACC_W-1:0];
				OP_PX: px0_q <= P0_W'(prod_q >>> 16);
				OP_PY: py0_q <= P0_W'(prod_q >>> 16);
				OP_PW: pw0_q <= P0_W'(prod_q >>> 16);
				OP_PZ: begin
					if (pz_full < 0)
						pz_q <= '0;
					else if (pz_full > PROD_W'(65535))
						pz_q <= '1;
					else
						pz_q <= pz_full[Z_W-1:0];
				end
				default: ;
			endcase
		end
		if (state_q == ST_LUT) begin
			s_q <= TRIG_TAB[k_sin];
			c_q <= TRIG_TAB[k_cos];
		end
		if (load_out) begin
			out_leg_q  <= leg_q;
			out_mov_q  <= trav_q;
			out_last_q <= (leg_q == LEG_W'(LEG_COUNT - 1));
			if (stepping && lifted && trav_q) begin
				out_x_q <= sat32(PROD_W'(px0_q));
				out_y_q <= sat32(PROD_W'(py0_q));
				out_w_q <= sat32(PROD_W'(pw0_q));
				out_z_q <= pz_q;
			end else if (stepping && !lifted) begin
				out_x_q <= sat32(-PROD_W'(px0_q));
				out_y_q <= sat32(-PROD_W'(py0_q));
				out_w_q <= sat32(-PROD_W'(pw0_q));
				out_z_q <= '0;
			end else begin
				out_x_q <= '0;
				out_y_q <= '0;
				out_w_q <= '0;
				out_z_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign leg       = out_leg_q;
	assign pos_x     = out_x_q;
	assign pos_y     = out_y_q;
	assign pos_z     = out_z_q;
	assign foot_yaw  = out_w_q;
	assign moving    = out_mov_q;
	assign last_leg  = out_last_q;

endmodule
